// File: sv/oaht_pkg.sv
// package for the open-addressing hash table
// field widths, operation and status codes, register indexes and defaults
// no dependencies
`default_nettype none

package oaht_pkg;

    localparam int unsigned MODE_W   = 2;
    localparam int unsigned VALUE_W  = 31;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned SIZE_W   = 8;
    localparam int unsigned CFG_IDX_W = 1;

    localparam int unsigned DEF_TABLE_DEPTH = 128;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 1'd1;

    localparam logic [SIZE_W-1:0] RST_TABLE_SIZE = 8'd128;

endpackage

`default_nettype wire

// File: sv/oaht_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module oaht_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  wire                       i_clk,
    input  wire                       i_wr_en,
    input  wire [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire [WIDTH-1:0]           i_wr_data,
    input  wire                       i_rd_en,
    input  wire [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [WIDTH-1:0]          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/oaht_mod_unit.sv
// iterative remainder unit, value mod size, two quotient bits per cycle
// depends on oaht_pkg
`default_nettype none

module oaht_mod_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [oaht_pkg::VALUE_W-1:0]  i_dividend,
    input  wire [oaht_pkg::SIZE_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [oaht_pkg::SIZE_W-1:0]  o_rem
);
    import oaht_pkg::*;

    localparam int unsigned DVD_W = VALUE_W + (VALUE_W % 2);
    localparam int unsigned STEPS = DVD_W / 2;
    localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [DVD_W-1:0]    r_dvd;
    logic [SIZE_W-1:0]   r_div;
    logic [SIZE_W-1:0]   r_rem;
    logic [SIZE_W-1:0]   n_rem;

    always_comb begin
        logic [SIZE_W:0] t;
        logic [SIZE_W-1:0] rem;
        rem = r_rem;
        for (int b = 0; b < 2; b++) begin
            t = {rem, r_dvd[DVD_W-1-b]};
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            rem = t[SIZE_W-1:0];
        end
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= DVD_W'(i_dividend);
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-3:0], 2'b00};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// File: sv/open_addressing_hash_table.sv
// open-addressing hash table over one slot ram; depends on oaht_pkg, oaht_ram, oaht_mod_unit
// insert, search, delete: the remainder of the value by the table size gives the home slot, then
//   slot ram probes up to table_size, a last check and the result load
// full, empty and unknown mode: no remainder and no probe, the result load follows acceptance
// one transaction at a time: the next input is taken after the result load, later while the
//   result waits on i_out_stall; after reset all TABLE_DEPTH ram slots are cleared first
`default_nettype none

module open_addressing_hash_table #(
    parameter int unsigned TABLE_DEPTH = oaht_pkg::DEF_TABLE_DEPTH
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire [oaht_pkg::MODE_W-1:0]     i_mode,
    input  wire [oaht_pkg::VALUE_W-1:0]    i_value,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [oaht_pkg::STATUS_W-1:0]  o_status,
    output logic [oaht_pkg::POS_W-1:0]     o_position,
    output logic [oaht_pkg::COUNT_W-1:0]   o_entry_count,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [oaht_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [oaht_pkg::SIZE_W-1:0]     i_cfg_data
);
    import oaht_pkg::*;

    localparam int unsigned AW       = $clog2(TABLE_DEPTH);
    localparam int unsigned SIZE_CAP = (TABLE_DEPTH > 255) ? 255 : TABLE_DEPTH;
    localparam int unsigned ENTRY_W  = VALUE_W + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } t_entry;

    function automatic logic [SIZE_W-1:0] mod_add(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b,
                                                  input logic [SIZE_W-1:0] m);
        logic [SIZE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[SIZE_W-1:0];
    endfunction

    logic [2:0]          r_state, n_state;
    logic [MODE_W-1:0]   r_mode, n_mode;
    logic [VALUE_W-1:0]  r_value, n_value;
    logic [SIZE_W-1:0]   r_sz, n_sz;
    logic [SIZE_W-1:0]   r_home, n_home;
    logic [SIZE_W-1:0]   r_q, n_q;
    logic [SIZE_W-1:0]   r_d, n_d;
    logic [SIZE_W-1:0]   r_issue_cnt, n_issue_cnt;
    logic                r_chk_vld, n_chk_vld;
    logic [SIZE_W-1:0]   r_chk_slot, n_chk_slot;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [SIZE_W-1:0]   r_pos, n_pos;
    logic [AW-1:0]       r_clr, n_clr;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [POS_W-1:0]    r_out_pos, n_out_pos;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;
    logic [SIZE_W-1:0]   r_table_size;
    logic                r_probe_mode;

    logic [SIZE_W-1:0]   eff_sz;
    logic                in_accept;
    logic                div_start;
    logic                div_done;
    logic [SIZE_W-1:0]   div_rem;
    logic                issue;
    logic [SIZE_W-1:0]   slot_now;
    logic [SIZE_W-1:0]   one_mod;
    logic [SIZE_W-1:0]   inc;
    logic [SIZE_W:0]     d_sum;
    logic                hit;
    t_entry              rd_entry;
    logic [ENTRY_W-1:0]  rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    t_entry              wr_entry;

    always_comb begin
        if (r_table_size == '0) begin
            eff_sz = SIZE_W'(1);
        end else if (r_table_size > SIZE_W'(SIZE_CAP)) begin
            eff_sz = SIZE_W'(SIZE_CAP);
        end else begin
            eff_sz = r_table_size;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign div_start = in_accept &&
        ((i_mode == MODE_INSERT && r_count < COUNT_W'(eff_sz)) ||
         ((i_mode == MODE_SEARCH || i_mode == MODE_DELETE) && r_count != '0));

    oaht_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_value),
        .i_divisor  (eff_sz),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign rd_entry = t_entry'(rd_data);
    assign issue    = (r_state == S_PROBE) && (r_issue_cnt != r_sz);
    assign slot_now = mod_add(r_home, r_q, r_sz);
    assign one_mod  = (r_sz == SIZE_W'(1)) ? '0 : SIZE_W'(1);
    assign inc      = r_probe_mode ? r_d : one_mod;

    always_comb begin
        d_sum = {1'b0, r_d} + (SIZE_W + 1)'(2);
        if (d_sum >= {1'b0, r_sz}) begin
            d_sum = d_sum - {1'b0, r_sz};
        end
        if (d_sum >= {1'b0, r_sz}) begin
            d_sum = d_sum - {1'b0, r_sz};
        end
    end

    always_comb begin
        if (r_mode == MODE_INSERT) begin
            hit = r_chk_vld && !rd_entry.valid;
        end else begin
            hit = r_chk_vld && rd_entry.valid && (rd_entry.value == r_value);
        end
    end

    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = r_clr;
        wr_entry = '0;
        if (r_state == S_CLEAR) begin
            wr_en = 1'b1;
        end else if (r_state == S_PROBE && hit && r_mode != MODE_SEARCH) begin
            wr_en          = 1'b1;
            wr_addr        = AW'(r_chk_slot);
            wr_entry.valid = (r_mode == MODE_INSERT);
            wr_entry.value = r_value;
        end
    end

    oaht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_en   (issue),
        .i_rd_addr (AW'(slot_now)),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_value      = r_value;
        n_sz         = r_sz;
        n_home       = r_home;
        n_q          = r_q;
        n_d          = r_d;
        n_issue_cnt  = r_issue_cnt;
        n_chk_vld    = r_chk_vld;
        n_chk_slot   = r_chk_slot;
        n_count      = r_count;
        n_status     = r_status;
        n_pos        = r_pos;
        n_clr        = r_clr;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_count  = r_out_count;

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_mode  = i_mode;
                    n_value = i_value;
                    n_sz    = eff_sz;
                    n_pos   = '0;
                    if (div_start) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_DONE;
                        if (i_mode == MODE_INSERT) begin
                            n_status = ST_FULL;
                        end else if (i_mode == MODE_SEARCH || i_mode == MODE_DELETE) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_home      = div_rem;
                    n_q         = '0;
                    n_d         = (r_sz == SIZE_W'(1)) ? '0 : SIZE_W'(1);
                    n_issue_cnt = '0;
                    n_chk_vld   = 1'b0;
                    n_state     = S_PROBE;
                end
            end
            S_PROBE: begin
                n_chk_vld  = issue;
                n_chk_slot = slot_now;
                if (issue) begin
                    n_q         = mod_add(r_q, inc, r_sz);
                    n_d         = d_sum[SIZE_W-1:0];
                    n_issue_cnt = r_issue_cnt + 1'b1;
                end
                if (hit) begin
                    n_status = ST_DONE;
                    n_pos    = r_chk_slot;
                    n_state  = S_DONE;
                    if (r_mode == MODE_INSERT) begin
                        n_count = r_count + 1'b1;
                    end else if (r_mode == MODE_DELETE) begin
                        n_count = r_count - 1'b1;
                    end
                end else if (r_chk_vld && !issue) begin
                    n_status = (r_mode == MODE_INSERT) ? ST_NO_SLOT : ST_NOT_FOUND;
                    n_pos    = '0;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_pos    = r_pos[POS_W-1:0];
                    n_out_count  = r_count;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_chk_vld    <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_table_size <= RST_TABLE_SIZE;
            r_probe_mode <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_chk_vld   <= n_chk_vld;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TABLE_SIZE: r_table_size <= i_cfg_data;
                    CFG_PROBE_MODE: r_probe_mode <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_value      <= n_value;
        r_sz         <= n_sz;
        r_home       <= n_home;
        r_q          <= n_q;
        r_d          <= n_d;
        r_issue_cnt  <= n_issue_cnt;
        r_chk_slot   <= n_chk_slot;
        r_status     <= n_status;
        r_pos        <= n_pos;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_count  <= n_out_count;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_position    = r_out_pos;
    assign o_entry_count = r_out_count;

endmodule

`default_nettype wire
